// File: rtl/spa_pkg.sv
// Shared constants and types of the spectrum averaging and peak hold block.
// Used by the item interfaces, the register file and the top level.
// Depends on nothing.
package spa_pkg;

    // Store geometry and field widths
    localparam int MAX_BINS  = 4096;
    localparam int MAG_BITS  = 24;
    localparam int BIN_BITS  = $clog2(MAX_BINS);
    localparam int ADDR_BITS = $clog2(2 * MAX_BINS);
    localparam int STORE_DEPTH = 2 * MAX_BINS;

    // Q0.16 coefficients, 17 bits so that 1.0 fits
    localparam int Q_BITS = 17;
    localparam logic [Q_BITS-1:0] Q_ONE = 17'h10000;

    // Product and sum widths of the fixed point datapath
    localparam int PROD_BITS = MAG_BITS + Q_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;

    // Configuration port
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_IDX_BITS  = 3;

    // Register indexes (byte address is four times the index)
    localparam logic [CFG_IDX_BITS-1:0] REG_PAUSE      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_AVG_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_HOLD  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_REF_FREEZE = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_PEAK_DECAY = 3'd5;

    // Reset values of the coefficient registers
    localparam logic [Q_BITS-1:0] AVG_WEIGHT_RESET = 17'd16384;
    localparam logic [Q_BITS-1:0] PEAK_DECAY_RESET = 17'd64880;

    // Configuration seen by the datapath
    typedef struct packed {
        logic              pause;
        logic              smooth_enable;
        logic [Q_BITS-1:0] average_weight;
        logic              peak_hold;
        logic              reference_freeze;
        logic [Q_BITS-1:0] peak_decay;
    } spa_cfg_t;

    // Request side of the register bus
    typedef struct packed {
        logic                     psel;
        logic                     penable;
        logic                     pwrite;
        logic [CFG_ADDR_BITS-1:0] paddr;
        logic [CFG_DATA_BITS-1:0] pwdata;
    } spa_apb_req_t;

    // Saturate a Q0.16 coefficient to 1.0
    function automatic logic [Q_BITS-1:0] sat_q(input logic [Q_BITS-1:0] v);
        sat_q = (v > Q_ONE) ? Q_ONE : v;
    endfunction

endpackage

// File: rtl/spa_bin_if.sv
// Input channel of the block: one spectrum bin per item.
// Depends on spa_pkg for field widths.
interface spa_bin_if;
    import spa_pkg::*;

    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] magnitude;
    logic                channel;
    logic [BIN_BITS-1:0] bin_num;
    logic                frame_last;

    modport source (output valid, magnitude, channel, bin_num, frame_last, input ready);
    modport sink   (input valid, magnitude, channel, bin_num, frame_last, output ready);
endinterface

// File: rtl/spa_res_if.sv
// Output channel of the block: display and peak value of one bin per item.
// Depends on spa_pkg for field widths.
interface spa_res_if;
    import spa_pkg::*;

    logic                valid;
    logic                ready;
    logic [MAG_BITS-1:0] display_value;
    logic [MAG_BITS-1:0] peak_value;
    logic                out_channel;
    logic [BIN_BITS-1:0] out_bin;
    logic                out_last;
    logic                frame_nonempty;

    modport source (output valid, display_value, peak_value, out_channel, out_bin,
                    out_last, frame_nonempty, input ready);
    modport sink   (input valid, display_value, peak_value, out_channel, out_bin,
                    out_last, frame_nonempty, output ready);
endinterface

// File: rtl/spa_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents. No dependencies.
module spa_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read; read data holds when re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// File: rtl/spa_regs.sv
// Configuration registers of the spectrum averaging block on an APB-style port.
// Depends on spa_pkg for register indexes, reset values and the config struct.
module spa_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spa_pkg::spa_apb_req_t               req,
    output logic [spa_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready,
    output spa_pkg::spa_cfg_t                   cfg
);
    import spa_pkg::*;

    spa_cfg_t                cfg_reg;
    logic                    wr_en;
    logic [CFG_IDX_BITS-1:0] idx;

    assign idx    = req.paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = req.psel && req.penable && req.pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes in the access phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pause            <= 1'b0;
            cfg_reg.smooth_enable    <= 1'b0;
            cfg_reg.average_weight   <= AVG_WEIGHT_RESET;
            cfg_reg.peak_hold        <= 1'b0;
            cfg_reg.reference_freeze <= 1'b0;
            cfg_reg.peak_decay       <= PEAK_DECAY_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PAUSE:      cfg_reg.pause            <= req.pwdata[0];
                REG_SMOOTH:     cfg_reg.smooth_enable    <= req.pwdata[0];
                REG_AVG_WEIGHT: cfg_reg.average_weight   <= req.pwdata[Q_BITS-1:0];
                REG_PEAK_HOLD:  cfg_reg.peak_hold        <= req.pwdata[0];
                REG_REF_FREEZE: cfg_reg.reference_freeze <= req.pwdata[0];
                REG_PEAK_DECAY: cfg_reg.peak_decay       <= req.pwdata[Q_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_PAUSE:      prdata[0]          = cfg_reg.pause;
            REG_SMOOTH:     prdata[0]          = cfg_reg.smooth_enable;
            REG_AVG_WEIGHT: prdata[Q_BITS-1:0] = cfg_reg.average_weight;
            REG_PEAK_HOLD:  prdata[0]          = cfg_reg.peak_hold;
            REG_REF_FREEZE: prdata[0]          = cfg_reg.reference_freeze;
            REG_PEAK_DECAY: prdata[Q_BITS-1:0] = cfg_reg.peak_decay;
            default:        prdata             = '0;
        endcase
    end
endmodule

// File: rtl/spectrum_average_peak_hold_core.sv
// Spectrum exponential averaging and peak hold core, top level.
// Depends on spa_pkg, spa_bin_if, spa_res_if, spa_ram and spa_regs.
//
// The core takes one bin per item and returns one result per item, at a
// sustained rate of one item per clock cycle while the output is not stalled;
// an accepted item passes the stage 1, stage 2 and stage 3 registers before
// its result is valid. Display and peak values of both channels live in two
// RAMs of 2*MAX_BINS entries each; a bin is read when it is accepted and
// written back from stage 2, and a two-entry write history forwards fresh
// values so that repeated bins in close succession see every earlier update.
// The averaging and decay multiplies sit in the same stage as that forwarding,
// which sets the one-item-per-cycle loop. After reset both RAMs are cleared in
// a pass over all 2*MAX_BINS addresses, during which no item is accepted;
// register writes are taken at any time. Registers sit at byte addresses 4*i:
// pause, smooth_enable, average_weight, peak_hold, reference_freeze, peak_decay.
module spectrum_average_peak_hold_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    spa_bin_if.sink                              bins_in,
    spa_res_if.source                            bins_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [spa_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  logic [spa_pkg::CFG_DATA_BITS-1:0]    pwdata,
    output logic [spa_pkg::CFG_DATA_BITS-1:0]    prdata,
    output logic                                 pready
);
    import spa_pkg::*;

    // One record of the write history
    typedef struct packed {
        logic                 valid;
        logic [ADDR_BITS-1:0] addr;
        logic [MAG_BITS-1:0]  disp;
        logic [MAG_BITS-1:0]  peak;
    } wr_rec_t;

    spa_apb_req_t apb_req;
    spa_cfg_t     cfg;

    // Clearing pass
    logic                 clear_done_reg;
    logic [ADDR_BITS-1:0] clear_addr_reg;

    // Stage handshake
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    logic in_acc, s2_write;

    // Stage 1 payload
    logic [MAG_BITS-1:0] mag1_reg;
    logic                chan1_reg;
    logic [BIN_BITS-1:0] bin1_reg;
    logic                last1_reg;

    // Stage 2 payload
    logic [MAG_BITS-1:0]  mag2_reg;
    logic                 chan2_reg;
    logic [BIN_BITS-1:0]  bin2_reg;
    logic                 last2_reg;
    logic [PROD_BITS-1:0] mw2_reg;
    logic [MAG_BITS-1:0]  disp_rd2_reg;
    logic [MAG_BITS-1:0]  peak_rd2_reg;

    // Stage 3 (output) payload
    logic [MAG_BITS-1:0] disp3_reg;
    logic [MAG_BITS-1:0] peak3_reg;
    logic                chan3_reg;
    logic [BIN_BITS-1:0] bin3_reg;
    logic                last3_reg;
    logic                nz3_reg;

    // Frame state
    logic frozen_reg, frozen_next;
    logic pend_reg, pend_next;
    logic nz_reg, nz_next;

    wr_rec_t h1_reg, h2_reg;

    // RAM ports
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [MAG_BITS-1:0]  disp_wdata, peak_wdata, disp_rdata, peak_rdata;

    // Stage 2 datapath
    logic [Q_BITS-1:0]    ws, wi, ds;
    logic [ADDR_BITS-1:0] addr2;
    logic [MAG_BITS-1:0]  disp_old, peak_old, disp_new, peak_new;
    logic [PROD_BITS-1:0] dw_prod, pd_prod;
    logic [SUM_BITS-1:0]  avg_sum;
    logic                 pend_eff, frozen_eff, nz_item;

    // Register file
    assign apb_req = '{psel: psel, penable: penable, pwrite: pwrite,
                       paddr: paddr, pwdata: pwdata};

    spa_regs u_regs (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (apb_req),
        .prdata (prdata),
        .pready (pready),
        .cfg    (cfg)
    );

    // Clearing pass over both stores after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_done_reg <= 1'b0;
            clear_addr_reg <= '0;
        end
        else if (!clear_done_reg)
        begin
            clear_addr_reg <= clear_addr_reg + ADDR_BITS'(1);
            if (clear_addr_reg == '1)
            begin
                clear_done_reg <= 1'b1;
            end
        end
    end

    // Stage enables: a stage moves when it is empty or its successor moves
    assign en3 = !v3_reg || bins_out.ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign bins_in.ready = en1 && clear_done_reg;
    assign in_acc   = bins_in.valid && bins_in.ready;
    assign s2_write = v2_reg && en3;

    // Coefficients saturated to 1.0
    assign ws = sat_q(cfg.average_weight);
    assign wi = Q_ONE - ws;
    assign ds = sat_q(cfg.peak_decay);

    // Store read at acceptance
    assign mem_raddr = {bins_in.channel, bins_in.bin_num};

    spa_ram #(.WIDTH(MAG_BITS), .DEPTH(STORE_DEPTH)) u_disp_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (disp_wdata),
        .re    (en1),
        .raddr (mem_raddr),
        .rdata (disp_rdata)
    );

    spa_ram #(.WIDTH(MAG_BITS), .DEPTH(STORE_DEPTH)) u_peak_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (peak_wdata),
        .re    (en1),
        .raddr (mem_raddr),
        .rdata (peak_rdata)
    );

    // Valid bits of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_acc;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage 1 and stage 2 payload; the new-sample product is formed in stage 1
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mag1_reg  <= bins_in.magnitude;
            chan1_reg <= bins_in.channel;
            bin1_reg  <= bins_in.bin_num;
            last1_reg <= bins_in.frame_last;
        end
        if (en2)
        begin
            mag2_reg     <= mag1_reg;
            chan2_reg    <= chan1_reg;
            bin2_reg     <= bin1_reg;
            last2_reg    <= last1_reg;
            mw2_reg      <= PROD_BITS'(mag1_reg) * PROD_BITS'(ws);
            disp_rd2_reg <= disp_rdata;
            peak_rd2_reg <= peak_rdata;
        end
    end

    // Stage 2: forward the two most recent writes over the RAM data
    assign addr2 = {chan2_reg, bin2_reg};

    always_comb
    begin
        disp_old = disp_rd2_reg;
        peak_old = peak_rd2_reg;
        if (h1_reg.valid && h1_reg.addr == addr2)
        begin
            disp_old = h1_reg.disp;
            peak_old = h1_reg.peak;
        end
        else if (h2_reg.valid && h2_reg.addr == addr2)
        begin
            disp_old = h2_reg.disp;
            peak_old = h2_reg.peak;
        end
    end

    // Stage 2: averaging and decay multiplies
    assign dw_prod = PROD_BITS'(disp_old) * PROD_BITS'(wi);
    assign pd_prod = PROD_BITS'(peak_old) * PROD_BITS'(ds);
    assign avg_sum = SUM_BITS'(mw2_reg) + SUM_BITS'(dw_prod);

    // Stage 2: freeze request as seen by this item
    assign pend_eff   = pend_reg || (cfg.reference_freeze && !frozen_reg);
    assign frozen_eff = cfg.reference_freeze && frozen_reg;

    // Stage 2: new display value
    always_comb
    begin
        if (cfg.pause)
        begin
            disp_new = disp_old;
        end
        else if (cfg.smooth_enable)
        begin
            disp_new = avg_sum[16 +: MAG_BITS];
        end
        else
        begin
            disp_new = mag2_reg;
        end
    end

    // Stage 2: new peak value; capture, hold with or without decay, or clear
    always_comb
    begin
        priority if (cfg.reference_freeze && pend_eff)
        begin
            peak_new = disp_new;
        end
        else if (cfg.peak_hold && !cfg.pause)
        begin
            if (mag2_reg > peak_old)
            begin
                peak_new = mag2_reg;
            end
            else if (!cfg.reference_freeze)
            begin
                peak_new = pd_prod[16 +: MAG_BITS];
            end
            else
            begin
                peak_new = peak_old;
            end
        end
        else if (!cfg.reference_freeze && !cfg.peak_hold)
        begin
            peak_new = '0;
        end
        else
        begin
            peak_new = peak_old;
        end
    end

    // Stage 2: frame state after this item
    assign nz_item = nz_reg || (disp_new != '0) || (peak_new != '0);

    always_comb
    begin
        pend_next   = pend_eff;
        frozen_next = frozen_eff;
        nz_next     = nz_item;
        if (last2_reg)
        begin
            nz_next = 1'b0;
            if (cfg.reference_freeze && pend_eff)
            begin
                pend_next   = 1'b0;
                frozen_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frozen_reg <= 1'b0;
            pend_reg   <= 1'b0;
            nz_reg     <= 1'b0;
            h1_reg     <= '0;
            h2_reg     <= '0;
        end
        else if (s2_write)
        begin
            frozen_reg <= frozen_next;
            pend_reg   <= pend_next;
            nz_reg     <= nz_next;
            h2_reg     <= h1_reg;
            h1_reg     <= '{valid: 1'b1, addr: addr2, disp: disp_new, peak: peak_new};
        end
    end

    // Store write-back, or zeros during the clearing pass
    assign mem_we     = !clear_done_reg || s2_write;
    assign mem_waddr  = clear_done_reg ? addr2 : clear_addr_reg;
    assign disp_wdata = clear_done_reg ? disp_new : '0;
    assign peak_wdata = clear_done_reg ? peak_new : '0;

    // Stage 3: output register
    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            disp3_reg <= disp_new;
            peak3_reg <= peak_new;
            chan3_reg <= chan2_reg;
            bin3_reg  <= bin2_reg;
            last3_reg <= last2_reg;
            nz3_reg   <= nz_item;
        end
    end

    assign bins_out.valid          = v3_reg;
    assign bins_out.display_value  = disp3_reg;
    assign bins_out.peak_value     = peak3_reg;
    assign bins_out.out_channel    = chan3_reg;
    assign bins_out.out_bin        = bin3_reg;
    assign bins_out.out_last       = last3_reg;
    assign bins_out.frame_nonempty = nz3_reg;

    // No item enters while the stores are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        bins_in.ready |-> clear_done_reg)
        else $error("item accepted during the clearing pass");

    // A pending freeze and a held freeze never coexist
    assert property (@(posedge clk) disable iff (!rst_n)
        !(pend_reg && frozen_reg))
        else $error("freeze pending while already frozen");

    // The reference only becomes frozen at the end of a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frozen_reg) |-> $past(s2_write && last2_reg))
        else $error("frozen set outside a frame end");

    // An item written back in stage 2 shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        s2_write |=> v3_reg)
        else $error("item lost between write-back and output");
endmodule
